FILE: design/watchdog_timer_registers_core_defines.svh
// Assertion macros for the watchdog timer register block.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef WATCHDOG_TIMER_REGISTERS_CORE_DEFINES_SVH
`define WATCHDOG_TIMER_REGISTERS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge outside reset.
`define WDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold outside reset.
`define WDT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define WDT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/wdt_pkg.sv
// Shared types and constants of the watchdog timer register block.
// No dependencies; imported by wdt_regfile and the top level.
package wdt_pkg;

    // Width of the load, elapsed and snapshot counters.
    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // Item operations.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_IDLE  = 2'd3
    } t_op;

    // Register byte offsets.
    localparam logic [11:0] OFS_CTRL   = 12'd0;
    localparam logic [11:0] OFS_LOAD   = 12'd4;
    localparam logic [11:0] OFS_VALUE  = 12'd8;
    localparam logic [11:0] OFS_KEY    = 12'd12;
    localparam logic [11:0] OFS_STATUS = 12'd16;

    // Key words and control bit positions.
    localparam logic [31:0] KEY_FEED = 32'h5A5A_5A5A;
    localparam logic [31:0] KEY_LOCK = 32'h1ACC_E551;
    localparam int CTRL_EN_BIT    = 0;
    localparam int CTRL_INTEN_BIT = 1;

    // Largest elapsed count; ticking stops there.
    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        t_op         operation;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
        logic        bad_offset;
    } t_result;

endpackage

FILE: design/wdt_if.sv
// Valid/ready channel interfaces for request items and result items.
// Self-contained; used by the top level ports.
interface wdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [11:0] reg_offset;
    logic [31:0] write_data;

    modport source (output valid, operation, reg_offset, write_data, input ready);
    modport sink (input valid, operation, reg_offset, write_data, output ready);
endinterface

interface wdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_out;
    logic        bad_offset;

    modport source (output valid, read_data, irq_out, bad_offset, input ready);
    modport sink (input valid, read_data, irq_out, bad_offset, output ready);
endinterface

FILE: design/wdt_regfile.sv
// Watchdog state registers and the single-pass update and read decode.
// Depends on wdt_pkg and the assertion macro header.
`include "watchdog_timer_registers_core_defines.svh"

module wdt_regfile import wdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_update,
    input  t_item   i_item,
    output t_result o_result
);

    logic [1:0] r_ctrl, n_ctrl;
    t_count     r_load, n_load;
    t_count     r_elapsed, n_elapsed;
    t_count     r_snapshot, n_snapshot;
    logic       r_timeout, n_timeout;
    logic       r_lock, n_lock;

    logic       en;
    t_count     cur_value;

    // Counter value as software sees it: live while enabled, frozen otherwise.
    assign en = r_ctrl[CTRL_EN_BIT];

    always_comb begin
        if (!en) begin
            cur_value = r_snapshot;
        end else if (r_elapsed >= r_load) begin
            cur_value = '0;
        end else begin
            cur_value = r_load - r_elapsed;
        end
    end

    // Next state and result for the item in the input register.
    always_comb begin
        logic [31:0] rd;
        logic        bad;
        logic [1:0]  nw;

        rd         = '0;
        bad        = 1'b0;
        nw         = i_item.write_data[1:0];
        n_ctrl     = r_ctrl;
        n_load     = r_load;
        n_elapsed  = r_elapsed;
        n_snapshot = r_snapshot;
        n_timeout  = r_timeout;
        n_lock     = r_lock;

        case (i_item.operation)
            OP_READ: begin
                case (i_item.reg_offset)
                    OFS_CTRL:   rd = {30'd0, r_ctrl};
                    OFS_LOAD:   rd = 32'(r_load);
                    OFS_VALUE:  rd = 32'(cur_value);
                    OFS_KEY:    rd = '0;
                    OFS_STATUS: rd = {31'd0, r_timeout};
                    default:    bad = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_offset)
                    OFS_CTRL: begin
                        if (!r_lock) begin
                            if (!en && nw[CTRL_EN_BIT]) begin
                                n_elapsed = '0;
                                n_timeout = 1'b0;
                            end else if (en && !nw[CTRL_EN_BIT]) begin
                                n_snapshot = cur_value;
                            end
                            n_ctrl = nw;
                        end
                    end
                    OFS_LOAD:  n_load = t_count'(i_item.write_data);
                    OFS_VALUE: n_load = r_load;
                    OFS_KEY: begin
                        if (i_item.write_data == KEY_FEED) begin
                            n_elapsed = '0;
                            n_timeout = 1'b0;
                        end else if (i_item.write_data == KEY_LOCK) begin
                            n_lock = 1'b1;
                        end
                    end
                    OFS_STATUS: begin
                        // Write-1-to-clear, then restart if still clear.
                        if (i_item.write_data[0]) begin
                            n_timeout = 1'b0;
                        end
                        if (en && !n_timeout) begin
                            n_elapsed = '0;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            OP_TICK: begin
                if (en && r_elapsed != COUNT_MAX) begin
                    n_elapsed = r_elapsed + t_count'(1);
                end
            end
            default: begin
                n_lock = r_lock;
            end
        endcase

        // Timeout against the live load, after the item's own update.
        if (n_ctrl[CTRL_EN_BIT] && n_load != '0 && n_elapsed >= n_load) begin
            n_timeout = 1'b1;
        end

        o_result.read_data  = rd;
        o_result.bad_offset = bad;
        o_result.irq_out    = n_timeout & n_ctrl[CTRL_INTEN_BIT];
    end

    // State registers; they move only when an item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_load     <= '0;
            r_elapsed  <= '0;
            r_snapshot <= '0;
            r_timeout  <= 1'b0;
            r_lock     <= 1'b0;
        end else if (i_update) begin
            r_ctrl     <= n_ctrl;
            r_load     <= n_load;
            r_elapsed  <= n_elapsed;
            r_snapshot <= n_snapshot;
            r_timeout  <= n_timeout;
            r_lock     <= n_lock;
        end
    end

    // The lock holds until reset.
    `WDT_ASSERT(a_lock_sticky, i_clk, i_rst_n, r_lock |=> r_lock, "lock released")
    // Timeout is raised only by an item.
    `WDT_ASSERT(a_timeout_by_item, i_clk, i_rst_n, $rose(r_timeout) |-> $past(i_update), "timeout rose without an item")
    // Control changes only through an item while unlocked.
    `WDT_ASSERT(a_ctrl_unlocked, i_clk, i_rst_n, !$stable(r_ctrl) |-> ($past(i_update) && !$past(r_lock)), "control changed while locked")
    // Elapsed count never wraps back to zero by a tick.
    `WDT_NEVER(a_no_wrap, i_clk, i_rst_n, i_update && i_item.operation == OP_TICK && r_elapsed == COUNT_MAX && n_elapsed != COUNT_MAX, "elapsed count wrapped")

endmodule

FILE: design/watchdog_timer_registers_core.sv
// Watchdog timer register block top level: input register, state update, result register.
// Depends on wdt_pkg, wdt_if and wdt_regfile.
//
// Each request item (register read, register write or counter tick) gives exactly one result
// item. Items are accepted one per clock cycle when the result side keeps up, and each result
// passes first through the input register, where the register state is read and updated in a
// single pass, and then through the result register. The rate is set by that single-pass
// update of the control, load, elapsed, snapshot and flag registers.
// When the result side stalls, the input register still takes one more item before the request
// side is held. Counter ticks arrive as items of their own; the block has no free-running timer.

module watchdog_timer_registers_core import wdt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wdt_req_if.sink      i_req,
    wdt_rsp_if.source    o_rsp
);

    logic    r_s1_valid, n_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    t_result result;
    logic    s1_adv;

    // Stage handshake: the input register empties into the result register when it is free.
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;

    always_comb begin
        n_s1_valid  = i_req.ready ? i_req.valid : r_s1_valid;
        n_out_valid = s1_adv ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    end

    // Register state and decode for the item in the input register.
    wdt_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (s1_adv),
        .i_item   (r_s1_item),
        .o_result (result)
    );

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, loaded on each transfer.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_item.operation  <= t_op'(i_req.operation);
            r_s1_item.reg_offset <= i_req.reg_offset;
            r_s1_item.write_data <= i_req.write_data;
        end
        if (s1_adv) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out.read_data;
    assign o_rsp.irq_out    = r_out.irq_out;
    assign o_rsp.bad_offset = r_out.bad_offset;

endmodule
